@@ design/esc_pkg.sv @@
package esc_pkg;

	// Pipeline depths (register stages)
	localparam int TEMP_LAT  = 6;
	localparam int PRE_LAT   = 7;
	localparam int DIV_BITS  = 64;
	localparam int DIV_LAT   = DIV_BITS + 2;
	localparam int POST_LAT  = 8;
	localparam int PRESS_LAT = PRE_LAT + DIV_LAT + POST_LAT;
	localparam int HUM_CORE  = 12;
	localparam int HUM_PAD   = PRESS_LAT - HUM_CORE;
	localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

	typedef enum logic [2:0] {
		REG_TEMP_CAL   = 3'd0,
		REG_PRESS_LOW  = 3'd1,
		REG_PRESS_HIGH = 3'd2,
		REG_MIXED_CAL  = 3'd3,
		REG_HUM_CAL    = 3'd4
	} reg_idx_t;

	localparam logic [23:0]        SENT_24      = 24'h800000;
	localparam logic [15:0]        SENT_16      = 16'h8000;
	localparam logic signed [33:0] TF_PRESS_OFS = 34'sd128000;
	localparam logic signed [31:0] TF_HUM_OFS   = 32'sd76800;
	localparam logic signed [63:0] C_2P47       = 64'sd140737488355328;
	localparam logic signed [63:0] C_3125       = 64'sd3125;
	localparam logic [20:0]        C_2P20       = 21'd1048576;
	localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
	localparam logic signed [63:0] P_MAX        = 64'sd549755813887;
	localparam logic signed [63:0] P_MIN        = -64'sd549755813888;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic [7:0]         h1;
		logic signed [15:0] h2;
		logic [7:0]         h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic [19:0] rp20;
		logic        pdis;
		logic [15:0] rh;
		logic        hdis;
	} raw_side_t;

	typedef struct packed {
		logic signed [31:0] tf;
		logic               tv;
		logic [23:0]        temp;
		raw_side_t          side;
	} tout_t;

	typedef struct packed {
		logic tv;
		logic pdis;
		logic zero;
	} ptag_t;

	typedef struct packed {
		logic [23:0] temp;
		logic        tv;
		logic [16:0] hum;
		logic        hv;
	} hres_t;

	// Signed divide by 2**k, truncating toward zero
	function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
		input int unsigned k);
		logic [31:0] bias;
		bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		return (x + $signed(bias)) >>> k;
	endfunction

	function automatic logic signed [63:0] sdiv64(input logic signed [63:0] x,
		input int unsigned k);
		logic [63:0] bias;
		bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
		return (x + $signed(bias)) >>> k;
	endfunction

endpackage

@@ design/esc_temp.sv @@
module esc_temp import esc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  cal_t        cal,
	input  logic [23:0] raw_temperature,
	input  logic [23:0] raw_pressure,
	input  logic [15:0] raw_humidity,
	output tout_t       tout
);

	logic signed [31:0] v1a_s1, v2a_s1;
	logic               tdis_s1, tdis_s2, tdis_s3, tdis_s4;
	raw_side_t          side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [31:0] m1_s2, sq_s2;
	logic signed [31:0] v1_s3, v2b_s3;
	logic signed [31:0] v1_s4, m3_s4;
	logic signed [31:0] tf_s5;
	logic               tv_s5;
	logic signed [31:0] tf_c, t5_c, tq_c;

	assign tf_c = v1_s4 + sdiv32(m3_s4, 14);
	assign t5_c = (tf_s5 <<< 2) + tf_s5 + 32'sd128;
	assign tq_c = sdiv32(t5_c, 8);

	always_ff @(posedge clk) begin
		if (en) begin
			v1a_s1       <= $signed({15'b0, raw_temperature[23:7]}) - $signed({15'b0, cal.t1, 1'b0});
			v2a_s1       <= $signed({16'b0, raw_temperature[23:8]}) - $signed({16'b0, cal.t1});
			tdis_s1      <= (raw_temperature == SENT_24);
			side_s1.rp20 <= raw_pressure[23:4];
			side_s1.pdis <= (raw_pressure == SENT_24);
			side_s1.rh   <= raw_humidity;
			side_s1.hdis <= (raw_humidity == SENT_16);

			m1_s2   <= v1a_s1 * cal.t2;
			sq_s2   <= v2a_s1 * v2a_s1;
			tdis_s2 <= tdis_s1;
			side_s2 <= side_s1;

			v1_s3   <= sdiv32(m1_s2, 11);
			v2b_s3  <= sdiv32(sq_s2, 12);
			tdis_s3 <= tdis_s2;
			side_s3 <= side_s2;

			v1_s4   <= v1_s3;
			m3_s4   <= v2b_s3 * cal.t3;
			tdis_s4 <= tdis_s3;
			side_s4 <= side_s3;

			tf_s5   <= tf_c;
			tv_s5   <= ~tdis_s4 & (tf_c != -32'sd1);
			side_s5 <= side_s4;

			tout.tf   <= tf_s5;
			tout.tv   <= tv_s5;
			tout.temp <= tv_s5 ? tq_c[23:0] : 24'd0;
			tout.side <= side_s5;
		end
	end

endmodule

@@ design/esc_div.sv @@
module esc_div import esc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	input  ptag_t              tag_i,
	output logic signed [63:0] quo,
	output ptag_t              tag_o
);

	logic [63:0] rem_s [DIV_BITS+1];
	logic [63:0] quo_s [DIV_BITS+1];
	logic [63:0] dvs_s [DIV_BITS+1];
	logic        neg_s [DIV_BITS+1];
	ptag_t       tag_s [DIV_BITS+1];
	logic [63:0] nabs, dabs;

	assign nabs = num[63] ? (~num + 64'd1) : num;
	assign dabs = den[63] ? (~den + 64'd1) : den;

	// Work on magnitudes; sign restored in the last stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			quo_s[0] <= nabs;
			dvs_s[0] <= dabs;
			neg_s[0] <= num[63] ^ den[63];
			tag_s[0] <= tag_i;
		end
	end

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
		logic [64:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[i], quo_s[i][63]};
			ge    = (trial >= {1'b0, dvs_s[i]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? 64'(trial - {1'b0, dvs_s[i]}) : trial[63:0];
				quo_s[i+1] <= {quo_s[i][62:0], ge};
				dvs_s[i+1] <= dvs_s[i];
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo   <= neg_s[DIV_BITS] ? $signed(~quo_s[DIV_BITS] + 64'd1)
				: $signed(quo_s[DIV_BITS]);
			tag_o <= tag_s[DIV_BITS];
		end
	end

endmodule

@@ design/esc_press.sv @@
module esc_press import esc_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  cal_t               cal,
	input  tout_t              tout,
	output logic signed [39:0] pres,
	output logic               pv
);

	logic signed [33:0] a_s1;
	logic [20:0]        d0_s1, d0_s2, d0_s3, d0_s4;
	ptag_t              tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic signed [63:0] aa_s2, ap5_s2, ap2_s2;
	logic signed [63:0] b1_s3, aap3_s3, ap5_s3, ap2_s3;
	logic signed [63:0] b_s4, c0_s4;
	logic signed [63:0] nd_s5, csum_s5;
	logic signed [63:0] num_s6, cp_s6;
	logic signed [63:0] num_s7, dc_s7;
	ptag_t              dtag_in, dtag;
	logic signed [63:0] dq;
	logic signed [63:0] d_s8, dd_s8, f0_s8;
	logic signed [63:0] d_s9, f_s9;
	logic [63:0]        ll_s9;
	logic [30:0]        cr_s9;
	logic signed [63:0] d_s10, f_s10;
	logic [63:0]        sq_s10;
	logic signed [63:0] d_s11, f_s11, e0_s11;
	logic signed [63:0] d_s12, f_s12, e_s12;
	logic signed [63:0] sum_s13;
	logic signed [63:0] g_s14;
	ptag_t              tag_s8, tag_s9, tag_s10, tag_s11, tag_s12, tag_s13, tag_s14;
	logic [31:0]        cr_c;
	logic               ok_c;

	always_comb begin
		dtag_in      = tag_s7;
		dtag_in.zero = (dc_s7 == 64'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1        <= 34'(tout.tf) - TF_PRESS_OFS;
			d0_s1       <= C_2P20 - {1'b0, tout.side.rp20};
			tag_s1.tv   <= tout.tv;
			tag_s1.pdis <= tout.side.pdis;
			tag_s1.zero <= 1'b0;

			aa_s2  <= a_s1 * a_s1;
			ap5_s2 <= a_s1 * cal.p5;
			ap2_s2 <= a_s1 * cal.p2;
			d0_s2  <= d0_s1;
			tag_s2 <= tag_s1;

			b1_s3   <= aa_s2 * cal.p6;
			aap3_s3 <= aa_s2 * cal.p3;
			ap5_s3  <= ap5_s2;
			ap2_s3  <= ap2_s2;
			d0_s3   <= d0_s2;
			tag_s3  <= tag_s2;

			b_s4   <= b1_s3 + (ap5_s3 <<< 17) + (64'(cal.p4) <<< 35);
			c0_s4  <= sdiv64(aap3_s3, 8) + (ap2_s3 <<< 12);
			d0_s4  <= d0_s3;
			tag_s4 <= tag_s3;

			nd_s5   <= $signed({12'b0, d0_s4, 31'b0}) - b_s4;
			csum_s5 <= c0_s4 + C_2P47;
			tag_s5  <= tag_s4;

			num_s6 <= nd_s5 * C_3125;
			cp_s6  <= csum_s5 * $signed({48'b0, cal.p1});
			tag_s6 <= tag_s5;

			num_s7 <= num_s6;
			dc_s7  <= sdiv64(cp_s6, 33);
			tag_s7 <= tag_s6;
		end
	end

	esc_div u_div (
		.clk   (clk),
		.en    (en),
		.num   (num_s7),
		.den   (dc_s7),
		.tag_i (dtag_in),
		.quo   (dq),
		.tag_o (dtag)
	);

	// Low 64 bits of dd*dd from 32-bit halves
	assign cr_c = dd_s8[31:0] * dd_s8[63:32];
	assign ok_c = tag_s14.tv & ~tag_s14.pdis;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s8   <= dq;
			dd_s8  <= sdiv64(dq, 13);
			f0_s8  <= dq * cal.p8;
			tag_s8 <= dtag;

			ll_s9  <= {32'b0, dd_s8[31:0]} * {32'b0, dd_s8[31:0]};
			cr_s9  <= cr_c[30:0];
			f_s9   <= sdiv64(f0_s8, 19);
			d_s9   <= d_s8;
			tag_s9 <= tag_s8;

			sq_s10  <= ll_s9 + {cr_s9, 33'b0};
			f_s10   <= f_s9;
			d_s10   <= d_s9;
			tag_s10 <= tag_s9;

			e0_s11  <= $signed(sq_s10) * cal.p9;
			f_s11   <= f_s10;
			d_s11   <= d_s10;
			tag_s11 <= tag_s10;

			e_s12   <= sdiv64(e0_s11, 25);
			f_s12   <= f_s11;
			d_s12   <= d_s11;
			tag_s12 <= tag_s11;

			sum_s13 <= d_s12 + e_s12 + f_s12;
			tag_s13 <= tag_s12;

			g_s14   <= sdiv64(sum_s13, 8) + (64'(cal.p7) <<< 4);
			tag_s14 <= tag_s13;

			pv <= ok_c;
			if (!ok_c || tag_s14.zero) begin
				pres <= '0;
			end else if (g_s14 > P_MAX) begin
				pres <= P_MAX[39:0];
			end else if (g_s14 < P_MIN) begin
				pres <= P_MIN[39:0];
			end else begin
				pres <= g_s14[39:0];
			end
		end
	end

endmodule

@@ design/esc_hum.sv @@
module esc_hum import esc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  cal_t  cal,
	input  tout_t tout,
	output hres_t hres
);

	typedef struct packed {
		logic [23:0] temp;
		logic        tv;
		logic        hv;
	} hcar_t;

	hcar_t              car_s1, car_s2, car_s3, car_s4, car_s5, car_s6;
	hcar_t              car_s7, car_s8, car_s9, car_s10, car_s11, car_s12;
	logic signed [31:0] x1_s1, x2_s1;
	logic signed [31:0] x2_s2, mh5_s2, mh6_s2, mh3_s2;
	logic signed [31:0] x5_s3, x2p_s3, x3p_s3;
	logic signed [31:0] x5_s4, m_s4;
	logic signed [31:0] x5_s5, x4p_s5;
	logic signed [31:0] x5_s6, m2_s6;
	logic signed [31:0] x5_s7, x2pp_s7;
	logic signed [31:0] x3_s8, x3_s9, x3_s10, x3_s11, x3_s12;
	logic signed [31:0] q_s9, qq_s10, x4pp_s11, m3_s12;
	logic signed [31:0] x5f_c;
	logic [31:0]        hc_c;
	hres_t              pad_s [HUM_PAD];
	logic               hv_c;

	assign x5f_c = x3_s12 - sdiv32(m3_s12, 4);
	assign hv_c  = car_s12.hv;

	always_comb begin
		if (x5f_c < 32'sd0) begin
			hc_c = 32'd0;
		end else if (x5f_c > HUM_MAX) begin
			hc_c = HUM_MAX;
		end else begin
			hc_c = x5f_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1       <= tout.tf - TF_HUM_OFS;
			x2_s1       <= $signed({2'b0, tout.side.rh, 14'b0});
			car_s1.temp <= tout.temp;
			car_s1.tv   <= tout.tv;
			car_s1.hv   <= tout.tv & ~tout.side.hdis;

			x2_s2  <= x2_s1;
			mh5_s2 <= x1_s1 * cal.h5;
			mh6_s2 <= x1_s1 * cal.h6;
			mh3_s2 <= x1_s1 * $signed({1'b0, cal.h3});
			car_s2 <= car_s1;

			x5_s3  <= sdiv32(x2_s2 - $signed({cal.h4, 20'b0}) - mh5_s2 + 32'sd16384, 15);
			x2p_s3 <= sdiv32(mh6_s2, 10);
			x3p_s3 <= sdiv32(mh3_s2, 11) + 32'sd32768;
			car_s3 <= car_s2;

			x5_s4  <= x5_s3;
			m_s4   <= x2p_s3 * x3p_s3;
			car_s4 <= car_s3;

			x5_s5  <= x5_s4;
			x4p_s5 <= sdiv32(m_s4, 10) + 32'sd2097152;
			car_s5 <= car_s4;

			x5_s6  <= x5_s5;
			m2_s6  <= x4p_s5 * cal.h2;
			car_s6 <= car_s5;

			x5_s7   <= x5_s6;
			x2pp_s7 <= sdiv32(m2_s6 + 32'sd8192, 14);
			car_s7  <= car_s6;

			x3_s8  <= x5_s7 * x2pp_s7;
			car_s8 <= car_s7;

			x3_s9  <= x3_s8;
			q_s9   <= sdiv32(x3_s8, 15);
			car_s9 <= car_s8;

			x3_s10  <= x3_s9;
			qq_s10  <= q_s9 * q_s9;
			car_s10 <= car_s9;

			x3_s11   <= x3_s10;
			x4pp_s11 <= sdiv32(qq_s10, 7);
			car_s11  <= car_s10;

			x3_s12  <= x3_s11;
			m3_s12  <= x4pp_s11 * $signed({1'b0, cal.h1});
			car_s12 <= car_s11;

			pad_s[0].temp <= car_s12.temp;
			pad_s[0].tv   <= car_s12.tv;
			pad_s[0].hv   <= hv_c;
			pad_s[0].hum  <= hv_c ? hc_c[28:12] : 17'd0;
			for (int i = 1; i < HUM_PAD; i++) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
	end

	// Align with the pressure path
	assign hres = pad_s[HUM_PAD-1];

endmodule

@@ design/environmental_sensor_compensation.sv @@
// An accepted input transaction passes every register stage to its result
// (6 temperature stages, 7 pressure set-up stages, a 66-stage radix-2
// divider, 8 pressure finishing stages); humidity runs alongside.
// Throughput: one transaction per cycle; a stalled result freezes all stages.
// Reset: arst_n clears the valid bits and all calibration registers to zero.
module environmental_sensor_compensation import esc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [63:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        raw_temperature,
	input  logic [23:0]        raw_pressure,
	input  logic [15:0]        raw_humidity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] temperature_centi,
	output logic               temperature_valid,
	output logic signed [39:0] pressure_q24_8,
	output logic               pressure_valid,
	output logic [16:0]        humidity_q22_10,
	output logic               humidity_valid
);

	logic [47:0]          temp_cal_q;
	logic [63:0]          press_low_q;
	logic [63:0]          press_high_q;
	logic [47:0]          mixed_cal_q;
	logic [31:0]          hum_cal_q;
	cal_t                 cal;
	logic [TOTAL_LAT-1:0] vld_s;
	logic                 en;
	tout_t                tout;
	hres_t                hres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			mixed_cal_q  <= '0;
			hum_cal_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEMP_CAL:   temp_cal_q   <= wr_data[47:0];
				REG_PRESS_LOW:  press_low_q  <= wr_data;
				REG_PRESS_HIGH: press_high_q <= wr_data;
				REG_MIXED_CAL:  mixed_cal_q  <= wr_data[47:0];
				REG_HUM_CAL:    hum_cal_q    <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cal.t1 = temp_cal_q[15:0];
		cal.t2 = temp_cal_q[31:16];
		cal.t3 = temp_cal_q[47:32];
		cal.p1 = press_low_q[15:0];
		cal.p2 = press_low_q[31:16];
		cal.p3 = press_low_q[47:32];
		cal.p4 = press_low_q[63:48];
		cal.p5 = press_high_q[15:0];
		cal.p6 = press_high_q[31:16];
		cal.p7 = press_high_q[47:32];
		cal.p8 = press_high_q[63:48];
		cal.p9 = mixed_cal_q[15:0];
		cal.h1 = mixed_cal_q[23:16];
		cal.h2 = mixed_cal_q[39:24];
		cal.h3 = mixed_cal_q[47:40];
		cal.h4 = hum_cal_q[11:0];
		cal.h5 = hum_cal_q[23:12];
		cal.h6 = hum_cal_q[31:24];
	end

	// Advance unless a finished result is held by the consumer
	assign en       = ~(vld_s[TOTAL_LAT-1] & out_stall);
	assign in_stall = ~en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL_LAT-2:0], in_valid};
		end
	end

	esc_temp u_temp (
		.clk             (clk),
		.en              (en),
		.cal             (cal),
		.raw_temperature (raw_temperature),
		.raw_pressure    (raw_pressure),
		.raw_humidity    (raw_humidity),
		.tout            (tout)
	);

	esc_press u_press (
		.clk  (clk),
		.en   (en),
		.cal  (cal),
		.tout (tout),
		.pres (pressure_q24_8),
		.pv   (pressure_valid)
	);

	esc_hum u_hum (
		.clk  (clk),
		.en   (en),
		.cal  (cal),
		.tout (tout),
		.hres (hres)
	);

	assign out_valid         = vld_s[TOTAL_LAT-1];
	assign temperature_centi = $signed(hres.temp);
	assign temperature_valid = hres.tv;
	assign humidity_q22_10   = hres.hum;
	assign humidity_valid    = hres.hv;

endmodule

@@ design/esc_chk.sv @@
module esc_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               wr_en,
	input logic [2:0]         wr_index,
	input logic [63:0]        wr_data,
	input logic               in_valid,
	input logic               in_stall,
	input logic [23:0]        raw_temperature,
	input logic [23:0]        raw_pressure,
	input logic [15:0]        raw_humidity,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [23:0] temperature_centi,
	input logic               temperature_valid,
	input logic signed [39:0] pressure_q24_8,
	input logic               pressure_valid,
	input logic [16:0]        humidity_q22_10,
	input logic               humidity_valid
);

	// Hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_q24_8)
			&& $stable(temperature_centi) && $stable(humidity_q22_10))
		else $error("stalled result changed");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output back-pressure");

	a_tflag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !temperature_valid |-> !pressure_valid && !humidity_valid
			&& temperature_centi == 24'sd0 && pressure_q24_8 == 40'sd0
			&& humidity_q22_10 == 17'd0)
		else $error("invalid temperature left other results set");

	a_hrange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity above full scale");

endmodule

bind environmental_sensor_compensation esc_chk u_chk (.*);
